// ===== rtl/aar_pkg.sv =====
`timescale 1ns / 1ps
package aar_pkg;

	// working format: 30 fraction bits
	localparam int WORK_FB = 30;
	// square-root cells: two radicand bits each, 32 root bits
	localparam int SQ_N = 32;
	// divider cells: one quotient bit each, quotient below 2^31
	localparam int DV_N = 31;
	// CORDIC start value, gain compensation 0.6072529350
	localparam logic signed [32:0] GAIN_INIT = 33'sd652032874;

	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef logic [2:0][31:0] rem3_t;
	typedef logic [2:0][30:0] quot3_t;
	typedef logic [8:0][15:0] mat_t;

	// side data of one item while the root and quotients form
	typedef struct packed {
		logic            zero;
		logic [2:0]      neg;
		logic [2:0][15:0] mag;
	} side_t;

	// control bundle handed to the matrix stages
	typedef struct packed {
		logic       vld;
		logic       zero;
		logic [2:0] neg;
	} mctl_t;

endpackage

// ===== rtl/axis_angle_rotation_matrix.sv =====
`timescale 1ns / 1ps
// Channel   Handshake            Beat
// input     start, busy          turn_angle, axis_x, axis_y, axis_z
// result    done (one cycle)     m_r0_c0 .. m_r2_c2, zero_axis
//
// One beat is taken every cycle; busy stays low.
// A beat passes an input register, 32 square-root cells, 31 divider
// cells and five matrix stages. The CORDIC cells run beside the root.
// Reset clears the valid line and the matrix control line; results in flight are lost.
// The receiver cannot stall: each result shows for exactly one cycle.
module axis_angle_rotation_matrix #(
	parameter int FRAC_BITS     = 14,
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [15:0]        turn_angle,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	output logic               done,
	output logic signed [15:0] m_r0_c0,
	output logic signed [15:0] m_r0_c1,
	output logic signed [15:0] m_r0_c2,
	output logic signed [15:0] m_r1_c0,
	output logic signed [15:0] m_r1_c1,
	output logic signed [15:0] m_r1_c2,
	output logic signed [15:0] m_r2_c0,
	output logic signed [15:0] m_r2_c1,
	output logic signed [15:0] m_r2_c2,
	output logic               zero_axis
);

	localparam int SQ_N  = aar_pkg::SQ_N;
	localparam int DV_N  = aar_pkg::DV_N;
	localparam int FRONT = SQ_N + DV_N;
	localparam int CN    = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
	localparam int CD    = FRONT - CN;
	localparam int LAT   = FRONT + 6;

	logic [FRONT:0]      vld_q;
	aar_pkg::side_t      side_q [FRONT+1];
	logic [15:0]         ang_s1;
	logic [31:0]         sum_s1;
	logic [31:0]         sum_w;

	logic [63:0] rad_c  [SQ_N+1];
	logic [33:0] rem_c  [SQ_N+1];
	logic [31:0] root_c [SQ_N+1];

	logic [31:0]      droot_c [DV_N+1];
	aar_pkg::rem3_t   drem_c  [DV_N+1];
	aar_pkg::quot3_t  dquot_c [DV_N+1];

	logic signed [32:0] cx_c [CN+1];
	logic signed [32:0] cy_c [CN+1];
	logic signed [33:0] cz_c [CN+1];
	logic               cf_c [CN+1];

	logic signed [32:0] cv_q [CD];
	logic signed [32:0] sv_q [CD];

	aar_pkg::mctl_t     mctl;
	aar_pkg::mat_t      ent;
	aar_pkg::side_t     side_w;

	assign busy = 1'b0;

	// sum of squares and side data of the incoming beat
	always_comb begin
		sum_w = 32'(axis_x * axis_x) + 32'(axis_y * axis_y) + 32'(axis_z * axis_z);
		side_w.zero   = (axis_x == 16'sd0) && (axis_y == 16'sd0) && (axis_z == 16'sd0);
		side_w.neg    = {axis_z[15], axis_y[15], axis_x[15]};
		side_w.mag[0] = axis_x[15] ? 16'(-axis_x) : axis_x;
		side_w.mag[1] = axis_y[15] ? 16'(-axis_y) : axis_y;
		side_w.mag[2] = axis_z[15] ? 16'(-axis_z) : axis_z;
	end

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[FRONT-1:0], start};
		end
	end

	// side data line, aligned with the cells
	always_ff @(posedge clk) begin
		ang_s1    <= turn_angle;
		sum_s1    <= sum_w;
		side_q[0] <= side_w;
		for (int k = 1; k <= FRONT; k++) begin
			side_q[k] <= side_q[k-1];
		end
	end

	// square-root row
	assign rad_c[0]  = {sum_s1, 32'd0};
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
		aar_sqrt_cell u_cell (
			.clk    (clk),
			.rad    (rad_c[g]),
			.rem    (rem_c[g]),
			.root   (root_c[g]),
			.rad_q  (rad_c[g+1]),
			.rem_q  (rem_c[g+1]),
			.root_q (root_c[g+1])
		);
	end

	// divider row: magnitude * 2^46 over the root, three lanes
	assign droot_c[0] = root_c[SQ_N];
	assign dquot_c[0] = '0;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			drem_c[0][i] = {1'b0, side_q[SQ_N].mag[i], 15'd0};
		end
	end

	for (genvar g = 0; g < DV_N; g++) begin : g_div
		aar_div_cell u_cell (
			.clk    (clk),
			.root   (droot_c[g]),
			.rem    (drem_c[g]),
			.quot   (dquot_c[g]),
			.root_q (droot_c[g+1]),
			.rem_q  (drem_c[g+1]),
			.quot_q (dquot_c[g+1])
		);
	end

	// CORDIC row; second and third quadrants turn by half a turn
	assign cx_c[0] = aar_pkg::GAIN_INIT;
	assign cy_c[0] = '0;
	assign cz_c[0] = {{3{ang_s1[14]}}, ang_s1[14:0], 16'd0};
	assign cf_c[0] = ang_s1[15] ^ ang_s1[14];

	for (genvar g = 0; g < CN; g++) begin : g_cordic
		aar_cordic_cell #(.IDX(g)) u_cell (
			.clk    (clk),
			.x      (cx_c[g]),
			.y      (cy_c[g]),
			.z      (cz_c[g]),
			.flip   (cf_c[g]),
			.x_q    (cx_c[g+1]),
			.y_q    (cy_c[g+1]),
			.z_q    (cz_c[g+1]),
			.flip_q (cf_c[g+1])
		);
	end

	// undo the half turn and hold cos, sin until the quotients arrive
	always_ff @(posedge clk) begin
		cv_q[0] <= cf_c[CN] ? -cx_c[CN] : cx_c[CN];
		sv_q[0] <= cf_c[CN] ? -cy_c[CN] : cy_c[CN];
		for (int k = 1; k < CD; k++) begin
			cv_q[k] <= cv_q[k-1];
			sv_q[k] <= sv_q[k-1];
		end
	end

	// matrix stages
	always_comb begin
		mctl.vld  = vld_q[FRONT];
		mctl.zero = side_q[FRONT].zero;
		mctl.neg  = side_q[FRONT].neg;
	end

	aar_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mctl),
		.quot   (dquot_c[DV_N]),
		.cv     (cv_q[CD-1]),
		.sv     (sv_q[CD-1]),
		.done   (done),
		.zero   (zero_axis),
		.ent    (ent)
	);

	assign m_r0_c0 = ent[0];
	assign m_r0_c1 = ent[1];
	assign m_r0_c2 = ent[2];
	assign m_r1_c0 = ent[3];
	assign m_r1_c1 = ent[4];
	assign m_r1_c2 = ent[5];
	assign m_r2_c0 = ent[6];
	assign m_r2_c1 = ent[7];
	assign m_r2_c2 = ent[8];

	// a result only follows a matching beat taken earlier
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching beat");

	// the zero flag comes only with a result
	a_zero_done: assert property (@(posedge clk) disable iff (!arst_n)
		zero_axis |-> done)
		else $error("zero flag outside a result");

	// a zero axis yields zero off-diagonal entries
	a_zero_ident: assert property (@(posedge clk) disable iff (!arst_n)
		zero_axis |-> (m_r0_c1 == 16'sd0) && (m_r0_c2 == 16'sd0) && (m_r1_c0 == 16'sd0)
			&& (m_r1_c2 == 16'sd0) && (m_r2_c0 == 16'sd0) && (m_r2_c1 == 16'sd0))
		else $error("zero axis result is not the identity");

	// the valid line only carries beats that were taken
	a_vld_src: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] |-> $past(start))
		else $error("valid line entry without a beat");

endmodule

// ===== rtl/aar_sqrt_cell.sv =====
`timescale 1ns / 1ps
module aar_sqrt_cell (
	input  logic        clk,
	input  logic [63:0] rad,
	input  logic [33:0] rem,
	input  logic [31:0] root,
	output logic [63:0] rad_q,
	output logic [33:0] rem_q,
	output logic [31:0] root_q
);

	logic [35:0] rem2;
	logic [35:0] trial;
	logic        ge;

	// bring down two radicand bits and try the next root bit
	always_comb begin
		rem2  = {rem, rad[63:62]};
		trial = {2'b00, root, 2'b01};
		ge    = (rem2 >= trial);
	end

	always_ff @(posedge clk) begin
		rad_q  <= {rad[61:0], 2'b00};
		rem_q  <= ge ? 34'(rem2 - trial) : rem2[33:0];
		root_q <= {root[30:0], ge};
	end

endmodule

// ===== rtl/aar_div_cell.sv =====
`timescale 1ns / 1ps
module aar_div_cell (
	input  logic                 clk,
	input  logic [31:0]          root,
	input  aar_pkg::rem3_t       rem,
	input  aar_pkg::quot3_t      quot,
	output logic [31:0]          root_q,
	output aar_pkg::rem3_t       rem_q,
	output aar_pkg::quot3_t      quot_q
);

	logic [2:0][32:0] rem2;
	logic [2:0]       ge;

	// one restoring step per lane; dividend bits below are all zero
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem2[i] = {rem[i], 1'b0};
			ge[i]   = (rem2[i] >= {1'b0, root});
		end
	end

	always_ff @(posedge clk) begin
		root_q <= root;
		for (int i = 0; i < 3; i++) begin
			rem_q[i]  <= ge[i] ? 32'(rem2[i] - {1'b0, root}) : rem2[i][31:0];
			quot_q[i] <= {quot[i][29:0], ge[i]};
		end
	end

endmodule

// ===== rtl/aar_cordic_cell.sv =====
`timescale 1ns / 1ps
module aar_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic signed [32:0] x,
	input  logic signed [32:0] y,
	input  logic signed [33:0] z,
	input  logic               flip,
	output logic signed [32:0] x_q,
	output logic signed [32:0] y_q,
	output logic signed [33:0] z_q,
	output logic               flip_q
);

	localparam logic signed [33:0] ANG = 34'(aar_pkg::ATAN_TURNS[IDX]);

	logic signed [32:0] dx;
	logic signed [32:0] dy;

	always_comb begin
		dx = y >>> IDX;
		dy = x >>> IDX;
	end

	// rotate toward zero residual angle
	always_ff @(posedge clk) begin
		flip_q <= flip;
		if (!z[33]) begin
			x_q <= x - dx;
			y_q <= y + dy;
			z_q <= z - ANG;
		end else begin
			x_q <= x + dx;
			y_q <= y - dy;
			z_q <= z + ANG;
		end
	end

endmodule

// ===== rtl/aar_matrix.sv =====
`timescale 1ns / 1ps
module aar_matrix #(
	parameter int FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  aar_pkg::mctl_t      ctl,
	input  aar_pkg::quot3_t     quot,
	input  logic signed [32:0]  cv,
	input  logic signed [32:0]  sv,
	output logic                done,
	output logic                zero,
	output aar_pkg::mat_t       ent
);

	localparam int SH = aar_pkg::WORK_FB - FRAC_BITS;
	localparam logic signed [36:0] HALF = (37'sd1 <<< SH) >>> 1;
	localparam logic signed [33:0] ONE34 = 34'sd1 <<< aar_pkg::WORK_FB;
	localparam logic signed [35:0] ONE36 = 36'sd1 <<< aar_pkg::WORK_FB;
	localparam int PA [6] = '{0, 1, 2, 0, 0, 1};
	localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

	aar_pkg::mctl_t ctl_s0, ctl_s1, ctl_s2, ctl_s3;
	logic                done_q, zero_q;
	aar_pkg::mat_t       ent_q;

	logic signed [31:0]      u_s0 [3];
	logic signed [32:0]      cv_s0, sv_s0;
	logic signed [33:0]      t_s0;

	logic signed [32:0]      pp_s1 [6];
	logic signed [33:0]      sx_s1 [3];
	logic signed [33:0]      t_s1;
	logic signed [32:0]      cv_s1;

	logic signed [34:0]      pt_s2 [6];
	logic signed [33:0]      sx_s2 [3];
	logic signed [32:0]      cv_s2;

	logic signed [35:0]      e_s3 [9];

	logic signed [63:0]      pp_w [6];
	logic signed [64:0]      sx_w [3];
	logic signed [66:0]      pt_w [6];
	logic signed [35:0]      e_w [9];
	logic signed [36:0]      ev [9];
	logic signed [36:0]      rv [9];
	aar_pkg::mat_t           sat_w;

	// control line, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
		end else begin
			ctl_s0 <= ctl;
			ctl_s1 <= ctl_s0;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			done_q <= ctl_s3.vld;
			zero_q <= ctl_s3.vld & ctl_s3.zero;
		end
	end

	// stage 0: signed unit components and 1 - cos
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			u_s0[i] <= ctl.neg[i] ? -$signed({1'b0, quot[i]}) : $signed({1'b0, quot[i]});
		end
		cv_s0 <= cv;
		sv_s0 <= sv;
		t_s0  <= ONE34 - 34'(cv);
	end

	// stage 1: axis products and axis times sine
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			pp_w[k] = 64'(u_s0[PA[k]]) * 64'(u_s0[PB[k]]);
		end
		for (int i = 0; i < 3; i++) begin
			sx_w[i] = 65'(u_s0[i]) * 65'(sv_s0);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) begin
			pp_s1[k] <= pp_w[k][62:30];
		end
		for (int i = 0; i < 3; i++) begin
			sx_s1[i] <= sx_w[i][63:30];
		end
		t_s1  <= t_s0;
		cv_s1 <= cv_s0;
	end

	// stage 2: scale each product by 1 - cos
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			pt_w[k] = 67'(pp_s1[k]) * 67'(t_s1);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) begin
			pt_s2[k] <= pt_w[k][64:30];
		end
		sx_s2 <= sx_s1;
		cv_s2 <= cv_s1;
	end

	// stage 3: add cosine on the diagonal and sine terms off it; a zero axis gives the identity
	always_comb begin
		if (ctl_s2.zero) begin
			for (int j = 0; j < 9; j++) begin
				e_w[j] = '0;
			end
			e_w[0] = ONE36;
			e_w[4] = ONE36;
			e_w[8] = ONE36;
		end else begin
			e_w[0] = 36'(pt_s2[0]) + 36'(cv_s2);
			e_w[1] = 36'(pt_s2[3]) - 36'(sx_s2[2]);
			e_w[2] = 36'(pt_s2[4]) + 36'(sx_s2[1]);
			e_w[3] = 36'(pt_s2[3]) + 36'(sx_s2[2]);
			e_w[4] = 36'(pt_s2[1]) + 36'(cv_s2);
			e_w[5] = 36'(pt_s2[5]) - 36'(sx_s2[0]);
			e_w[6] = 36'(pt_s2[4]) - 36'(sx_s2[1]);
			e_w[7] = 36'(pt_s2[5]) + 36'(sx_s2[0]);
			e_w[8] = 36'(pt_s2[2]) + 36'(cv_s2);
		end
	end

	always_ff @(posedge clk) begin
		e_s3 <= e_w;
	end

	// stage 4: round half up to the output format and saturate
	always_comb begin
		for (int j = 0; j < 9; j++) begin
			ev[j] = 37'(e_s3[j]) + HALF;
			rv[j] = ev[j] >>> SH;
			if (rv[j] > 37'sd32767) begin
				sat_w[j] = 16'h7FFF;
			end else if (rv[j] < -37'sd32768) begin
				sat_w[j] = 16'h8000;
			end else begin
				sat_w[j] = rv[j][15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= sat_w;
	end

	assign done = done_q;
	assign zero = zero_q;
	assign ent  = ent_q;

endmodule
